// ----- rtl/mlfq_pkg.sv -----
// mlfq_pkg: shared types, codes and sizes for the feedback-queue scheduler
// used by mlfq_cfg and mlfq_task_scheduler_unit; depends on nothing
`timescale 1ns / 1ps

package mlfq_pkg;

    localparam int MAX_TASKS  = 64;
    localparam int NUM_LEVELS = 4;
    localparam int ID_W       = $clog2(MAX_TASKS);
    localparam int LINK_W     = ID_W + 1;
    localparam int LVL_W      = $clog2(NUM_LEVELS);
    localparam int QNT_W      = 8;
    localparam int BOOST_W    = 16;
    localparam int TICK_W     = 32;
    localparam int TIME_W     = 64;
    localparam int CNT_W      = $clog2(TICK_W);
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [LINK_W-1:0] NIL       = LINK_W'(MAX_TASKS);
    localparam logic [LVL_W-1:0]  LAST_LVL  = LVL_W'(NUM_LEVELS - 1);

    localparam logic [QNT_W-1:0]   QNT0_RST  = 8'd2;
    localparam logic [QNT_W-1:0]   QNT1_RST  = 8'd4;
    localparam logic [QNT_W-1:0]   QNT2_RST  = 8'd8;
    localparam logic [QNT_W-1:0]   QNT3_RST  = 8'd16;
    localparam logic [BOOST_W-1:0] BOOST_RST = 16'd100;

    localparam logic [CFG_IDX_W-1:0] CFG_QNT0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QNT1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QNT2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_QNT3  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BOOST = 3'd4;

    typedef enum logic [2:0] {
        REQ_ADD     = 3'd0,
        REQ_TICK    = 3'd1,
        REQ_PREEMPT = 3'd2,
        REQ_YIELD   = 3'd3,
        REQ_SLEEP   = 3'd4,
        REQ_WAKE    = 3'd5,
        REQ_RETIRE  = 3'd6
    } req_code_t;

    typedef enum logic [1:0] {
        TS_FREE  = 2'd0,
        TS_READY = 2'd1,
        TS_RUN   = 2'd2,
        TS_SLEEP = 2'd3
    } task_state_t;

    typedef enum logic [1:0] {
        STAT_DONE      = 2'd0,
        STAT_NO_SWITCH = 2'd1,
        STAT_IGNORED   = 2'd2
    } stat_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_ADD_CHK,
        S_ENQ_RD,
        S_ENQ_WR,
        S_ENQ_LINK,
        S_SW_RD,
        S_SW_DEQ,
        S_SW_POP,
        S_TK_WALK,
        S_TK_CHK,
        S_TK_MOD,
        S_TK_BRD,
        S_TK_BWR,
        S_TK_BLINK,
        S_TK_BCUR,
        S_TK_CNT,
        S_TK_DEC,
        S_SLP_WR,
        S_WK_CHK,
        S_WK_WALK,
        S_WK_STEP,
        S_WK_FIN,
        S_FIN
    } fsm_t;

    typedef struct packed {
        logic [2:0]        req_type;
        logic [ID_W-1:0]   task_id;
        logic [LVL_W-1:0]  start_level;
        logic [TIME_W-1:0] now_ns;
        logic [TIME_W-1:0] wake_deadline;
    } req_word_t;

    typedef struct packed {
        logic             switched;
        logic [ID_W-1:0]  current_task;
        logic             running_idle;
        logic             reschedule_pending;
        logic [1:0]       status;
    } res_word_t;

    typedef struct packed {
        logic [QNT_W-1:0]   quantum;
        logic [QNT_W-1:0]   quantum0;
        logic [BOOST_W-1:0] boost;
    } cfg_view_t;

endpackage

// ----- rtl/mlfq_cfg.sv -----
// mlfq_cfg: quantum and boost interval registers with the per-level quantum lookup
// depends on mlfq_pkg
`timescale 1ns / 1ps

module mlfq_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               wr_en,
    input  logic [mlfq_pkg::CFG_IDX_W-1:0]     wr_index,
    input  logic [mlfq_pkg::CFG_DATA_W-1:0]    wr_data,
    input  logic [mlfq_pkg::LVL_W-1:0]         q_lvl,
    output mlfq_pkg::cfg_view_t                view
);
    import mlfq_pkg::*;

    logic [QNT_W-1:0]   qnt0_reg, qnt1_reg, qnt2_reg, qnt3_reg;
    logic [BOOST_W-1:0] boost_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qnt0_reg  <= QNT0_RST;
            qnt1_reg  <= QNT1_RST;
            qnt2_reg  <= QNT2_RST;
            qnt3_reg  <= QNT3_RST;
            boost_reg <= BOOST_RST;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                CFG_QNT0:  qnt0_reg  <= wr_data[QNT_W-1:0];
                CFG_QNT1:  qnt1_reg  <= wr_data[QNT_W-1:0];
                CFG_QNT2:  qnt2_reg  <= wr_data[QNT_W-1:0];
                CFG_QNT3:  qnt3_reg  <= wr_data[QNT_W-1:0];
                CFG_BOOST: boost_reg <= wr_data[BOOST_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        case (q_lvl)
            2'd0:    view.quantum = qnt0_reg;
            2'd1:    view.quantum = qnt1_reg;
            2'd2:    view.quantum = qnt2_reg;
            default: view.quantum = qnt3_reg;
        endcase
        view.quantum0 = qnt0_reg;
        view.boost    = boost_reg;
    end

endmodule

// ----- rtl/mlfq_task_scheduler_unit.sv -----
// mlfq_task_scheduler_unit: four-level feedback-queue scheduler, sequencer and task tables
// depends on mlfq_pkg and mlfq_cfg
`timescale 1ns / 1ps

// A request word is taken on a clock edge with start high and busy low; busy then
// stays high until the result word has been produced. The result is on result for
// exactly one cycle with done high and cannot be held off by the receiver. All task
// tables sit behind one read port, so a request reads them one visit after another:
// wake takes longer for each sleeper passed, and a tick walks every sleeper and wakes
// the tasks that are due, then, when the boost interval is non-zero, runs a bit-serial
// remainder step of the tick count against it and, on a boost, moves every task queued
// at levels 1 to 3 to level 0, and finally charges the running task its tick.
// After reset no clearing pass is needed; requests may start at once.
module mlfq_task_scheduler_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  mlfq_pkg::req_word_t              req,
    output logic                             busy,
    output logic                             done,
    output mlfq_pkg::res_word_t              result,
    input  logic                             wr_en,
    input  logic [mlfq_pkg::CFG_IDX_W-1:0]   wr_index,
    input  logic [mlfq_pkg::CFG_DATA_W-1:0]  wr_data
);
    import mlfq_pkg::*;

    // task tables
    logic [LINK_W-1:0] nl_mem [MAX_TASKS];
    logic [LVL_W-1:0]  lv_mem [MAX_TASKS];
    logic [QNT_W-1:0]  tk_mem [MAX_TASKS];
    task_state_t       st_mem [MAX_TASKS];
    logic [TIME_W-1:0] dl_mem [MAX_TASKS];
    logic [MAX_TASKS-1:0] tk_vld_reg, st_vld_reg;

    logic [LINK_W-1:0] nl_rd_reg;
    logic [LVL_W-1:0]  lv_rd_reg;
    logic [QNT_W-1:0]  tk_rd_reg;
    task_state_t       st_rd_reg;
    logic [TIME_W-1:0] dl_rd_reg;
    logic              tk_vrd_reg, st_vrd_reg;
    logic [QNT_W-1:0]  tk_rd;
    task_state_t       st_rd;

    logic [ID_W-1:0]   rd_addr;
    logic              nl_we, lv_we, tk_we, st_we, dl_we;
    logic [ID_W-1:0]   nl_wa, lv_wa, tk_wa, st_wa, dl_wa;
    logic [LINK_W-1:0] nl_wd;
    logic [LVL_W-1:0]  lv_wd;
    logic [QNT_W-1:0]  tk_wd;
    task_state_t       st_wd;
    logic [TIME_W-1:0] dl_wd;

    // scheduler state
    fsm_t              state_reg, state_next, ret_reg, ret_next;
    logic [LINK_W-1:0] head_reg [NUM_LEVELS];
    logic [LINK_W-1:0] head_next [NUM_LEVELS];
    logic [LINK_W-1:0] tail_reg [NUM_LEVELS];
    logic [LINK_W-1:0] tail_next [NUM_LEVELS];
    logic [LINK_W-1:0] sleep_head_reg, sleep_head_next;
    logic [ID_W-1:0]   cur_id_reg, cur_id_next;
    logic              idle_reg, idle_next;
    logic [TICK_W-1:0] tick_count_reg, tick_count_next;
    logic              resched_reg, resched_next;

    // sequencer working registers
    req_word_t         req_reg, req_next;
    logic [ID_W-1:0]   t_reg, t_next;
    logic [LINK_W-1:0] walk_reg, walk_next;
    logic [LINK_W-1:0] prev_reg, prev_next;
    logic [LINK_W-1:0] nxt_reg, nxt_next;
    logic [LVL_W-1:0]  lvl_reg, lvl_next;
    task_state_t       cur_st_reg, cur_st_next;
    logic [LVL_W-1:0]  cur_lvl_reg, cur_lvl_next;
    logic              pre_reg, pre_next;
    logic              sw_reg, sw_next;
    stat_t             stat_reg, stat_next;
    logic [TICK_W-1:0] md_reg, md_next;
    logic [BOOST_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              done_reg, done_next;
    res_word_t         result_reg, result_next;

    // shared unit and helpers
    logic [LVL_W-1:0]   q_lvl;
    cfg_view_t          cfg;
    logic [BOOST_W:0]   rem_wide;
    logic [BOOST_W-1:0] rem_step;
    logic               found;
    logic [LVL_W-1:0]   fidx;
    logic               due;
    logic [LVL_W-1:0]   new_lvl;
    logic [QNT_W-1:0]   tk_dec;

    mlfq_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .q_lvl    (q_lvl),
        .view     (cfg)
    );

    always_ff @(posedge clk)
    begin
        if (nl_we) nl_mem[nl_wa] <= nl_wd;
        if (lv_we) lv_mem[lv_wa] <= lv_wd;
        if (tk_we) tk_mem[tk_wa] <= tk_wd;
        if (st_we) st_mem[st_wa] <= st_wd;
        if (dl_we) dl_mem[dl_wa] <= dl_wd;
        nl_rd_reg <= nl_mem[rd_addr];
        lv_rd_reg <= lv_mem[rd_addr];
        tk_rd_reg <= tk_mem[rd_addr];
        st_rd_reg <= st_mem[rd_addr];
        dl_rd_reg <= dl_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tk_vld_reg <= '0;
            st_vld_reg <= '0;
            tk_vrd_reg <= 1'b0;
            st_vrd_reg <= 1'b0;
        end
        else
        begin
            if (tk_we) tk_vld_reg[tk_wa] <= 1'b1;
            if (st_we) st_vld_reg[st_wa] <= 1'b1;
            tk_vrd_reg <= tk_vld_reg[rd_addr];
            st_vrd_reg <= st_vld_reg[rd_addr];
        end
    end

    assign tk_rd = tk_vrd_reg ? tk_rd_reg : '0;
    assign st_rd = st_vrd_reg ? st_rd_reg : TS_FREE;

    // remainder step of the tick count against the boost interval
    assign rem_wide = {rem_reg, md_reg[TICK_W-1]};
    assign rem_step = (rem_wide >= {1'b0, cfg.boost})
                      ? BOOST_W'(rem_wide - {1'b0, cfg.boost}) : rem_wide[BOOST_W-1:0];

    always_comb
    begin
        found = 1'b0;
        fidx  = '0;
        for (int i = NUM_LEVELS - 1; i >= 0; i--)
        begin
            if (!head_reg[i][ID_W])
            begin
                found = 1'b1;
                fidx  = LVL_W'(i);
            end
        end
    end

    assign due     = (dl_rd_reg != '0) && (req_reg.now_ns >= dl_rd_reg);
    assign new_lvl = (pre_reg && cur_lvl_reg != LAST_LVL) ? cur_lvl_reg + 1'b1 : cur_lvl_reg;
    assign tk_dec  = (tk_rd != '0) ? tk_rd - 1'b1 : tk_rd;

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (req.req_type)
                        REQ_ADD:     state_next = S_ADD_CHK;
                        REQ_TICK:    state_next = S_TK_WALK;
                        REQ_PREEMPT: state_next = resched_reg ? S_SW_RD : S_FIN;
                        REQ_YIELD:   state_next = S_SW_RD;
                        REQ_SLEEP:   state_next = idle_reg ? S_SW_RD : S_SLP_WR;
                        REQ_WAKE:    state_next = S_WK_CHK;
                        REQ_RETIRE:  state_next = idle_reg ? S_FIN : S_SW_RD;
                        default:     state_next = S_FIN;
                    endcase
                end
            end
            S_ADD_CHK:
            begin
                if (st_rd != TS_FREE)
                    state_next = S_FIN;
                else
                begin
                    state_next = S_ENQ_RD;
                    ret_next   = S_FIN;
                end
            end
            S_ENQ_RD:   state_next = S_ENQ_WR;
            S_ENQ_WR:   state_next = tail_reg[lv_rd_reg][ID_W] ? ret_reg : S_ENQ_LINK;
            S_ENQ_LINK: state_next = ret_reg;
            S_SW_RD:    state_next = S_SW_DEQ;
            S_SW_DEQ:   state_next = found ? S_SW_POP : S_FIN;
            S_SW_POP:
            begin
                if (!idle_reg && cur_st_reg == TS_RUN)
                begin
                    state_next = S_ENQ_RD;
                    ret_next   = S_FIN;
                end
                else
                    state_next = S_FIN;
            end
            S_TK_WALK:
            begin
                if (walk_reg[ID_W])
                    state_next = (cfg.boost == '0) ? S_TK_CNT : S_TK_MOD;
                else
                    state_next = S_TK_CHK;
            end
            S_TK_CHK:
            begin
                if (due)
                begin
                    state_next = S_ENQ_RD;
                    ret_next   = S_TK_WALK;
                end
                else
                    state_next = S_TK_WALK;
            end
            S_TK_MOD:
            begin
                if (cnt_reg == CNT_W'(TICK_W - 1))
                    state_next = (rem_step == '0) ? S_TK_BRD : S_TK_CNT;
            end
            S_TK_BRD:
            begin
                if (!walk_reg[ID_W])
                    state_next = S_TK_BWR;
                else if (lvl_reg == LAST_LVL)
                    state_next = S_TK_BCUR;
            end
            S_TK_BWR:   state_next = tail_reg[0][ID_W] ? S_TK_BRD : S_TK_BLINK;
            S_TK_BLINK: state_next = S_TK_BRD;
            S_TK_BCUR:  state_next = S_TK_CNT;
            S_TK_CNT:   state_next = idle_reg ? S_FIN : S_TK_DEC;
            S_TK_DEC:   state_next = S_FIN;
            S_SLP_WR:   state_next = S_SW_RD;
            S_WK_CHK:   state_next = (st_rd != TS_SLEEP) ? S_FIN : S_WK_WALK;
            S_WK_WALK:  state_next = walk_reg[ID_W] ? S_WK_FIN : S_WK_STEP;
            S_WK_STEP:
            begin
                if (walk_reg == {1'b0, req_reg.task_id})
                    state_next = S_WK_FIN;
                else
                    state_next = S_WK_WALK;
            end
            S_WK_FIN:
            begin
                state_next = S_ENQ_RD;
                ret_next   = S_FIN;
            end
            S_FIN:      state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // datapath and table writes
    always_comb
    begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        sleep_head_next = sleep_head_reg;
        cur_id_next     = cur_id_reg;
        idle_next       = idle_reg;
        tick_count_next = tick_count_reg;
        resched_next    = resched_reg;
        req_next        = req_reg;
        t_next          = t_reg;
        walk_next       = walk_reg;
        prev_next       = prev_reg;
        nxt_next        = nxt_reg;
        lvl_next        = lvl_reg;
        cur_st_next     = cur_st_reg;
        cur_lvl_next    = cur_lvl_reg;
        pre_next        = pre_reg;
        sw_next         = sw_reg;
        stat_next       = stat_reg;
        md_next         = md_reg;
        rem_next        = rem_reg;
        cnt_next        = cnt_reg;
        done_next       = 1'b0;
        result_next     = result_reg;

        rd_addr = t_reg;
        q_lvl   = lv_rd_reg;
        nl_we = 1'b0; nl_wa = t_reg; nl_wd = NIL;
        lv_we = 1'b0; lv_wa = t_reg; lv_wd = '0;
        tk_we = 1'b0; tk_wa = t_reg; tk_wd = '0;
        st_we = 1'b0; st_wa = t_reg; st_wd = TS_READY;
        dl_we = 1'b0; dl_wa = t_reg; dl_wd = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next  = req;
                    sw_next   = 1'b0;
                    stat_next = STAT_DONE;
                    pre_next  = 1'b0;
                    rd_addr   = (req.req_type == REQ_SLEEP) ? cur_id_reg : req.task_id;
                    unique case (req.req_type)
                        REQ_ADD, REQ_WAKE: ;
                        REQ_TICK:
                        begin
                            tick_count_next = tick_count_reg + 1'b1;
                            walk_next       = sleep_head_reg;
                            prev_next       = NIL;
                        end
                        REQ_PREEMPT:
                        begin
                            if (resched_reg)
                            begin
                                resched_next = 1'b0;
                                pre_next     = 1'b1;
                            end
                            else
                                stat_next = STAT_IGNORED;
                        end
                        REQ_YIELD, REQ_SLEEP: resched_next = 1'b0;
                        REQ_RETIRE:
                        begin
                            if (idle_reg)
                                stat_next = STAT_IGNORED;
                            else
                            begin
                                st_we = 1'b1; st_wa = cur_id_reg; st_wd = TS_FREE;
                                tk_we = 1'b1; tk_wa = cur_id_reg; tk_wd = '0;
                            end
                        end
                        default: stat_next = STAT_IGNORED;
                    endcase
                end
            end
            S_ADD_CHK:
            begin
                if (st_rd != TS_FREE)
                    stat_next = STAT_IGNORED;
                else
                begin
                    lv_we = 1'b1; lv_wa = req_reg.task_id; lv_wd = req_reg.start_level;
                    tk_we = 1'b1; tk_wa = req_reg.task_id; tk_wd = '0;
                    t_next = req_reg.task_id;
                end
            end
            S_ENQ_RD: rd_addr = t_reg;
            S_ENQ_WR:
            begin
                q_lvl = lv_rd_reg;
                st_we = 1'b1; st_wa = t_reg; st_wd = TS_READY;
                if (tk_rd == '0)
                begin
                    tk_we = 1'b1; tk_wa = t_reg; tk_wd = cfg.quantum;
                end
                nl_we = 1'b1; nl_wa = t_reg; nl_wd = NIL;
                lvl_next = lv_rd_reg;
                if (tail_reg[lv_rd_reg][ID_W])
                begin
                    head_next[lv_rd_reg] = {1'b0, t_reg};
                    tail_next[lv_rd_reg] = {1'b0, t_reg};
                end
            end
            S_ENQ_LINK:
            begin
                nl_we = 1'b1;
                nl_wa = tail_reg[lvl_reg][ID_W-1:0];
                nl_wd = {1'b0, t_reg};
                tail_next[lvl_reg] = {1'b0, t_reg};
            end
            S_SW_RD: rd_addr = cur_id_reg;
            S_SW_DEQ:
            begin
                cur_st_next  = st_rd;
                cur_lvl_next = lv_rd_reg;
                if (found)
                begin
                    nxt_next = head_reg[fidx];
                    lvl_next = fidx;
                    rd_addr  = head_reg[fidx][ID_W-1:0];
                end
                else
                begin
                    stat_next = STAT_NO_SWITCH;
                    if (!idle_reg && st_rd != TS_RUN)
                        idle_next = 1'b1;
                end
            end
            S_SW_POP:
            begin
                head_next[lvl_reg] = nl_rd_reg;
                if (nl_rd_reg[ID_W])
                    tail_next[lvl_reg] = NIL;
                st_we = 1'b1; st_wa = nxt_reg[ID_W-1:0]; st_wd = TS_RUN;
                cur_id_next = nxt_reg[ID_W-1:0];
                idle_next   = 1'b0;
                sw_next     = 1'b1;
                stat_next   = STAT_DONE;
                if (!idle_reg && cur_st_reg == TS_RUN)
                begin
                    q_lvl = new_lvl;
                    lv_we = 1'b1; lv_wa = cur_id_reg; lv_wd = new_lvl;
                    tk_we = 1'b1; tk_wa = cur_id_reg; tk_wd = cfg.quantum;
                    t_next = cur_id_reg;
                end
            end
            S_TK_WALK:
            begin
                if (walk_reg[ID_W])
                begin
                    md_next  = tick_count_reg;
                    rem_next = '0;
                    cnt_next = '0;
                end
                else
                    rd_addr = walk_reg[ID_W-1:0];
            end
            S_TK_CHK:
            begin
                walk_next = nl_rd_reg;
                if (due)
                begin
                    if (prev_reg[ID_W])
                        sleep_head_next = nl_rd_reg;
                    else
                    begin
                        nl_we = 1'b1; nl_wa = prev_reg[ID_W-1:0]; nl_wd = nl_rd_reg;
                    end
                    dl_we  = 1'b1; dl_wa = walk_reg[ID_W-1:0]; dl_wd = '0;
                    t_next = walk_reg[ID_W-1:0];
                end
                else
                    prev_next = walk_reg;
            end
            S_TK_MOD:
            begin
                rem_next = rem_step;
                md_next  = {md_reg[TICK_W-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                lvl_next  = LVL_W'(1);
                walk_next = head_reg[1];
            end
            S_TK_BRD:
            begin
                if (walk_reg[ID_W])
                begin
                    head_next[lvl_reg] = NIL;
                    tail_next[lvl_reg] = NIL;
                    if (lvl_reg != LAST_LVL)
                    begin
                        lvl_next  = lvl_reg + 1'b1;
                        walk_next = head_reg[lvl_reg + 1'b1];
                    end
                end
                else
                    rd_addr = walk_reg[ID_W-1:0];
            end
            S_TK_BWR:
            begin
                nxt_next = nl_rd_reg;
                lv_we = 1'b1; lv_wa = walk_reg[ID_W-1:0]; lv_wd = '0;
                tk_we = 1'b1; tk_wa = walk_reg[ID_W-1:0]; tk_wd = cfg.quantum0;
                nl_we = 1'b1; nl_wa = walk_reg[ID_W-1:0]; nl_wd = NIL;
                if (tail_reg[0][ID_W])
                begin
                    head_next[0] = walk_reg;
                    tail_next[0] = walk_reg;
                    walk_next    = nl_rd_reg;
                end
            end
            S_TK_BLINK:
            begin
                nl_we = 1'b1; nl_wa = tail_reg[0][ID_W-1:0]; nl_wd = walk_reg;
                tail_next[0] = walk_reg;
                walk_next    = nxt_reg;
            end
            S_TK_BCUR:
            begin
                if (!idle_reg)
                begin
                    lv_we = 1'b1; lv_wa = cur_id_reg; lv_wd = '0;
                    tk_we = 1'b1; tk_wa = cur_id_reg; tk_wd = cfg.quantum0;
                end
            end
            S_TK_CNT:
            begin
                if (idle_reg)
                    resched_next = 1'b1;
                else
                    rd_addr = cur_id_reg;
            end
            S_TK_DEC:
            begin
                tk_we = 1'b1; tk_wa = cur_id_reg; tk_wd = tk_dec;
                if (tk_dec == '0)
                    resched_next = 1'b1;
            end
            S_SLP_WR:
            begin
                q_lvl = lv_rd_reg;
                st_we = 1'b1; st_wa = cur_id_reg; st_wd = TS_SLEEP;
                tk_we = 1'b1; tk_wa = cur_id_reg; tk_wd = cfg.quantum;
                dl_we = 1'b1; dl_wa = cur_id_reg; dl_wd = req_reg.wake_deadline;
                nl_we = 1'b1; nl_wa = cur_id_reg; nl_wd = sleep_head_reg;
                sleep_head_next = {1'b0, cur_id_reg};
            end
            S_WK_CHK:
            begin
                if (st_rd != TS_SLEEP)
                    stat_next = STAT_IGNORED;
                else
                begin
                    walk_next = sleep_head_reg;
                    prev_next = NIL;
                end
            end
            S_WK_WALK:
            begin
                if (!walk_reg[ID_W])
                    rd_addr = walk_reg[ID_W-1:0];
            end
            S_WK_STEP:
            begin
                if (walk_reg == {1'b0, req_reg.task_id})
                begin
                    if (prev_reg[ID_W])
                        sleep_head_next = nl_rd_reg;
                    else
                    begin
                        nl_we = 1'b1; nl_wa = prev_reg[ID_W-1:0]; nl_wd = nl_rd_reg;
                    end
                end
                else
                begin
                    prev_next = walk_reg;
                    walk_next = nl_rd_reg;
                end
            end
            S_WK_FIN:
            begin
                dl_we  = 1'b1; dl_wa = req_reg.task_id; dl_wd = '0;
                t_next = req_reg.task_id;
            end
            S_FIN:
            begin
                done_next                      = 1'b1;
                result_next.switched           = sw_reg;
                result_next.current_task       = idle_reg ? '0 : cur_id_reg;
                result_next.running_idle       = idle_reg;
                result_next.reschedule_pending = resched_reg;
                result_next.status             = stat_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ret_reg        <= S_FIN;
            for (int i = 0; i < NUM_LEVELS; i++)
            begin
                head_reg[i] <= NIL;
                tail_reg[i] <= NIL;
            end
            sleep_head_reg <= NIL;
            cur_id_reg     <= '0;
            idle_reg       <= 1'b1;
            tick_count_reg <= '0;
            resched_reg    <= 1'b0;
            done_reg       <= 1'b0;
            result_reg     <= '0;
            cnt_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            ret_reg        <= ret_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            sleep_head_reg <= sleep_head_next;
            cur_id_reg     <= cur_id_next;
            idle_reg       <= idle_next;
            tick_count_reg <= tick_count_next;
            resched_reg    <= resched_next;
            done_reg       <= done_next;
            result_reg     <= result_next;
            cnt_reg        <= cnt_next;
        end
    end

    // working registers, no reset needed
    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        t_reg       <= t_next;
        walk_reg    <= walk_next;
        prev_reg    <= prev_next;
        nxt_reg     <= nxt_next;
        lvl_reg     <= lvl_next;
        cur_st_reg  <= cur_st_next;
        cur_lvl_reg <= cur_lvl_next;
        pre_reg     <= pre_next;
        sw_reg      <= sw_next;
        stat_reg    <= stat_next;
        md_reg      <= md_next;
        rem_reg     <= rem_next;
    end

endmodule
